@@ hdl/scba_pkg.sv @@
// Shared types and codes for the size-class block allocator.
package scba_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND,
		ST_DIV,
		ST_OPEN,
		ST_CUR_RD,
		ST_CUR_CHK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_NEW,
		ST_INIT,
		ST_TAKE_RD,
		ST_TAKE_HD,
		ST_TAKE_LNK,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_OUT
	} state_t;

	localparam logic [2:0] STAT_ALLOC      = 3'd0;
	localparam logic [2:0] STAT_FREED      = 3'd1;
	localparam logic [2:0] STAT_CLASS_FULL = 3'd2;
	localparam logic [2:0] STAT_CHUNK_FULL = 3'd3;
	localparam logic [2:0] STAT_UNMATCHED  = 3'd4;
	localparam logic [2:0] STAT_ZERO_SIZE  = 3'd5;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic REG_MAX_BLOCKS = 1'b0;
	localparam logic REG_BYTE_LIMIT = 1'b1;

	localparam logic [7:0]  MAX_BLOCKS_RST = 8'd255;
	localparam logic [15:0] BYTE_LIMIT_RST = 16'd2048;
	localparam int          LINK_W         = 8;

	typedef struct packed {
		logic [7:0] left;
		logic [7:0] blk;
		logic [3:0] chunk;
		logic [2:0] cls;
		logic [2:0] status;
	} res_t;

endpackage

@@ hdl/size_class_block_allocator.sv @@
// Size-class block allocator: class search, chunk scan and free-list sequencer.
// An allocate searches the classes, then tries the open chunk, scans the class's chunks
// and opens a new chunk if none has a free block; a new class first runs the iterative
// divider, and a new chunk first sweeps the links of all its blocks. A free searches the classes.
// Throughput: one beat at a time; s_axis_tready is high only while idle.
// Reset clears control and class table registers; datapath and memories are not cleared.
module size_class_block_allocator
	import scba_pkg::*;
#(
	parameter int SIZE_CLASSES     = 8,
	parameter int CHUNKS_PER_CLASS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // req_size, free_chunk, free_block
	input  logic        s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // status, class_index, chunk_index, block_index, blocks_left
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int CI_W   = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
	localparam int CN_W   = $clog2(SIZE_CLASSES + 1);
	localparam int CK_W   = (CHUNKS_PER_CLASS > 1) ? $clog2(CHUNKS_PER_CLASS) : 1;
	localparam int KC_W   = $clog2(CHUNKS_PER_CLASS + 1);
	localparam int SLOTS  = SIZE_CLASSES * CHUNKS_PER_CLASS;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LA_W   = SLOT_W + LINK_W;

	state_t state_q, state_d;

	logic [7:0]  max_blocks_q;
	logic [15:0] byte_limit_q;

	logic [15:0]     class_size_q [SIZE_CLASSES];
	logic [7:0]      class_bpc_q  [SIZE_CLASSES];
	logic [KC_W-1:0] class_cnt_q  [SIZE_CLASSES];
	logic [CK_W-1:0] cur_q        [SIZE_CLASSES];
	logic [SIZE_CLASSES-1:0] cur_v_q;
	logic [CN_W-1:0] classes_q;

	logic        op_q;
	logic [15:0] size_q;
	logic [3:0]  fch_q;
	logic [7:0]  fbl_q;

	logic [CN_W-1:0] cls_i_q;
	logic [CI_W-1:0] c_q;
	logic [CK_W-1:0] k_q;
	logic [KC_W-1:0] idx_q;
	logic [7:0]      init_i_q;
	logic [3:0]      div_cnt_q;
	logic [16:0]     rem_q;
	logic [15:0]     quo_q;

	res_t res_q;
	logic m_valid_q;
	res_t m_res_q;

	logic [15:0]       chunk_mem [SLOTS];
	logic [LINK_W-1:0] link_mem  [SLOTS * 256];
	logic [15:0]       chunk_rd;
	logic [LINK_W-1:0] link_rd;

	logic              chunk_we;
	logic [SLOT_W-1:0] chunk_waddr, chunk_raddr;
	logic [15:0]       chunk_wdata;
	logic              link_we;
	logic [LA_W-1:0]   link_waddr, link_raddr;
	logic [LINK_W-1:0] link_wdata;

	logic [CI_W-1:0] ci;
	logic            cls_end, cls_hit, free_ok;
	logic [16:0]     div_r;
	logic            div_ge;
	logic [7:0]      bpc_new;
	logic [SLOT_W-1:0] slot_ck, slot_cur, slot_idx;
	logic            in_beat;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [CI_W-1:0] c,
			input logic [CK_W-1:0] k);
		return SLOT_W'(int'(c) * CHUNKS_PER_CLASS + int'(k));
	endfunction

	assign in_beat = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, m_res_q};

	assign ci      = cls_i_q[CI_W-1:0];
	assign cls_end = (cls_i_q == classes_q);
	assign cls_hit = !cls_end && (class_size_q[ci] == size_q);
	assign free_ok = (32'(fch_q) < 32'(class_cnt_q[ci])) &&
		(32'(fch_q) < CHUNKS_PER_CLASS) && (fbl_q < class_bpc_q[ci]);

	assign div_r  = {rem_q[15:0], quo_q[15]};
	assign div_ge = (div_r >= {1'b0, size_q});
	assign bpc_new = (quo_q == 16'd0 || max_blocks_q == 8'd0) ? 8'd1 :
		((16'(max_blocks_q) > quo_q) ? quo_q[7:0] : max_blocks_q);

	assign slot_ck  = slot_of(c_q, k_q);
	assign slot_cur = slot_of(c_q, cur_q[c_q]);
	assign slot_idx = slot_of(c_q, idx_q[CK_W-1:0]);

	always_ff @(posedge clk) begin
		chunk_rd <= chunk_mem[chunk_raddr];
		if (chunk_we) begin
			chunk_mem[chunk_waddr] <= chunk_wdata;
		end
	end

	always_ff @(posedge clk) begin
		link_rd <= link_mem[link_raddr];
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		chunk_raddr = slot_ck;
		chunk_we    = 1'b0;
		chunk_waddr = slot_ck;
		chunk_wdata = 16'd0;
		link_raddr  = {slot_ck, chunk_rd[15:8]};
		link_we     = 1'b0;
		link_waddr  = {slot_ck, fbl_q};
		link_wdata  = chunk_rd[15:8];
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					state_d = (s_axis_tdata[15:0] == 16'd0) ? ST_OUT : ST_FIND;
				end
			end
			ST_FIND: begin
				if (cls_hit) begin
					if (op_q == OP_FREE) begin
						state_d = free_ok ? ST_FREE_RD : ST_OUT;
					end else begin
						state_d = ST_CUR_RD;
					end
				end else if (cls_end) begin
					if (op_q == OP_FREE || 32'(classes_q) >= SIZE_CLASSES) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_cnt_q == 4'd15) begin
					state_d = ST_OPEN;
				end
			end
			ST_OPEN: state_d = ST_CUR_RD;
			ST_CUR_RD: begin
				chunk_raddr = slot_cur;
				state_d = ST_CUR_CHK;
			end
			ST_CUR_CHK: begin
				state_d = (cur_v_q[c_q] && chunk_rd[7:0] != 8'd0) ? ST_TAKE_RD : ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				chunk_raddr = slot_idx;
				state_d = (idx_q == class_cnt_q[c_q]) ? ST_NEW : ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				state_d = (chunk_rd[7:0] != 8'd0) ? ST_TAKE_RD : ST_SCAN_RD;
			end
			ST_NEW: begin
				if (32'(class_cnt_q[c_q]) >= CHUNKS_PER_CLASS) begin
					state_d = ST_OUT;
				end else begin
					chunk_we    = 1'b1;
					chunk_waddr = slot_of(c_q, class_cnt_q[c_q][CK_W-1:0]);
					chunk_wdata = {8'd0, class_bpc_q[c_q]};
					state_d     = ST_INIT;
				end
			end
			ST_INIT: begin
				link_we    = 1'b1;
				link_waddr = {slot_ck, init_i_q};
				link_wdata = init_i_q + 8'd1;
				if (init_i_q == class_bpc_q[c_q] - 8'd1) begin
					state_d = ST_TAKE_RD;
				end
			end
			ST_TAKE_RD: state_d = ST_TAKE_HD;
			ST_TAKE_HD: state_d = ST_TAKE_LNK;
			ST_TAKE_LNK: begin
				chunk_we    = 1'b1;
				chunk_wdata = {link_rd, chunk_rd[7:0] - 8'd1};
				state_d     = ST_OUT;
			end
			ST_FREE_RD: state_d = ST_FREE_CHK;
			ST_FREE_CHK: begin
				if (chunk_rd[7:0] < class_bpc_q[c_q]) begin
					link_we     = 1'b1;
					chunk_we    = 1'b1;
					chunk_wdata = {fbl_q, chunk_rd[7:0] + 8'd1};
				end
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_blocks_q <= MAX_BLOCKS_RST;
			byte_limit_q <= BYTE_LIMIT_RST;
			classes_q    <= '0;
			cur_v_q      <= '0;
			m_valid_q    <= 1'b0;
			for (int i = 0; i < SIZE_CLASSES; i++) begin
				class_size_q[i] <= '0;
				class_bpc_q[i]  <= '0;
				class_cnt_q[i]  <= '0;
				cur_q[i]        <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_BLOCKS: max_blocks_q <= cfg_wdata[7:0];
					REG_BYTE_LIMIT: byte_limit_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_OPEN: begin
					classes_q          <= classes_q + CN_W'(1);
					class_size_q[c_q]  <= size_q;
					class_bpc_q[c_q]   <= bpc_new;
					class_cnt_q[c_q]   <= '0;
					cur_q[c_q]         <= '0;
					cur_v_q[c_q]       <= 1'b0;
				end
				ST_NEW: begin
					if (32'(class_cnt_q[c_q]) < CHUNKS_PER_CLASS) begin
						class_cnt_q[c_q] <= class_cnt_q[c_q] + KC_W'(1);
					end
				end
				ST_TAKE_LNK: begin
					cur_q[c_q]   <= k_q;
					cur_v_q[c_q] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
			m_res_q <= res_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				op_q    <= s_axis_tuser;
				size_q  <= s_axis_tdata[15:0];
				fch_q   <= s_axis_tdata[19:16];
				fbl_q   <= s_axis_tdata[27:20];
				cls_i_q <= '0;
				res_q   <= '{status: STAT_ZERO_SIZE, default: '0};
			end
			ST_FIND: begin
				cls_i_q <= cls_i_q + CN_W'(1);
				k_q     <= CK_W'(fch_q);
				if (cls_end) begin
					c_q <= CI_W'(classes_q);
					if (op_q == OP_ALLOC) begin
						res_q <= '{status: STAT_CLASS_FULL, default: '0};
					end else begin
						res_q <= '{status: STAT_UNMATCHED, default: '0};
					end
				end else begin
					c_q   <= ci;
					res_q <= '{status: STAT_UNMATCHED, default: '0};
				end
				rem_q     <= '0;
				quo_q     <= byte_limit_q;
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				div_cnt_q <= div_cnt_q + 4'd1;
				rem_q     <= div_ge ? (div_r - {1'b0, size_q}) : div_r;
				quo_q     <= {quo_q[14:0], div_ge};
			end
			ST_CUR_RD: k_q <= cur_q[c_q];
			ST_CUR_CHK: idx_q <= '0;
			ST_SCAN_RD: k_q <= idx_q[CK_W-1:0];
			ST_SCAN_CHK: idx_q <= idx_q + KC_W'(1);
			ST_NEW: begin
				k_q      <= class_cnt_q[c_q][CK_W-1:0];
				init_i_q <= '0;
				res_q    <= '{status: STAT_CHUNK_FULL, cls: 3'(c_q), default: '0};
			end
			ST_INIT: init_i_q <= init_i_q + 8'd1;
			ST_TAKE_LNK: begin
				res_q <= '{status: STAT_ALLOC, cls: 3'(c_q), chunk: 4'(k_q),
					blk: chunk_rd[15:8], left: chunk_rd[7:0] - 8'd1};
			end
			ST_FREE_CHK: begin
				if (chunk_rd[7:0] < class_bpc_q[c_q]) begin
					res_q <= '{status: STAT_FREED, cls: 3'(c_q), chunk: 4'(k_q),
						blk: fbl_q, left: chunk_rd[7:0] + 8'd1};
				end
			end
			default: ;
		endcase
	end

endmodule

@@ hdl/scba_checker.sv @@
// Port-level checks for the size-class block allocator.
module scba_checker
	import scba_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted a beat while busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= STAT_ZERO_SIZE)
		else $error("bad status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] == STAT_CLASS_FULL ||
		m_axis_tdata[2:0] == STAT_UNMATCHED || m_axis_tdata[2:0] == STAT_ZERO_SIZE)
		|-> m_axis_tdata[25:3] == 23'd0)
		else $error("error result carries a handle");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
